// File: hw/rtl/bty_pkg.sv
// Shared types and constants for the BGRA to YUV 4:2:0 converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bty_pkg;

    localparam int CFG_W        = 13;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int DEF_MAX_DIM  = 4096;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_W-1:0] DEF_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] DEF_HEIGHT = 13'd1080;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [15:0] C_Y_R  = 16'd66;
    localparam logic [15:0] C_Y_G  = 16'd129;
    localparam logic [15:0] C_Y_B  = 16'd25;
    localparam logic [15:0] C_CB_R = 16'd38;
    localparam logic [15:0] C_CB_G = 16'd74;
    localparam logic [15:0] C_CB_B = 16'd112;
    localparam logic [15:0] C_CR_R = 16'd112;
    localparam logic [15:0] C_CR_G = 16'd94;
    localparam logic [15:0] C_CR_B = 16'd18;
    localparam logic [7:0]  Y_OFFSET     = 8'd16;
    localparam logic [15:0] CHROMA_BIAS  = 16'h8000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       chroma_valid;
        logic       line_end;
        logic       frame_end;
    } t_pix_word;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

`default_nettype wire

// File: hw/rtl/bty_front.sv
// Front end: accepts pixels, tracks column and row, tags chroma and line/frame ends.
// Depends on bty_pkg; feeds bty_queue.
`timescale 1ns / 1ps
`default_nettype none

module bty_front
    import bty_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIM
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_frame_width,
    input  wire logic [CFG_W-1:0] i_frame_height,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_blue,
    input  wire logic [7:0]       i_green,
    input  wire logic [7:0]       i_red,
    input  wire t_queue_status    i_queue_status,
    output logic                  o_push,
    output t_pix_word             o_push_word
);

    localparam int DW = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
    localparam int EW = (CFG_W > DW + 1) ? CFG_W : DW + 1;

    logic [DW-1:0] r_column_count, n_column_count;
    logic [DW-1:0] r_row_count, n_row_count;
    logic [DW-1:0] width_m1, height_m1;
    logic [EW-1:0] width_ext, height_ext;
    logic          accept, line_end, frame_end;

    assign width_ext  = EW'(i_frame_width);
    assign height_ext = EW'(i_frame_height);

    always_comb begin
        priority if (width_ext == '0) begin
            width_m1 = '0;
        end else if (width_ext > EW'(MAX_DIMENSION)) begin
            width_m1 = DW'(MAX_DIMENSION - 1);
        end else begin
            width_m1 = DW'(width_ext - EW'(1));
        end
        priority if (height_ext == '0) begin
            height_m1 = '0;
        end else if (height_ext > EW'(MAX_DIMENSION)) begin
            height_m1 = DW'(MAX_DIMENSION - 1);
        end else begin
            height_m1 = DW'(height_ext - EW'(1));
        end
    end

    assign o_in_ready = !i_queue_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign line_end   = r_column_count >= width_m1;
    assign frame_end  = line_end && (r_row_count >= height_m1);

    always_comb begin
        n_column_count = r_column_count;
        n_row_count    = r_row_count;
        if (accept) begin
            if (line_end) begin
                n_column_count = '0;
                n_row_count    = frame_end ? '0 : r_row_count + DW'(1);
            end else begin
                n_column_count = r_column_count + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= '0;
            r_row_count    <= '0;
        end else begin
            r_column_count <= n_column_count;
            r_row_count    <= n_row_count;
        end
    end

    assign o_push                   = accept;
    assign o_push_word.blue         = i_blue;
    assign o_push_word.green        = i_green;
    assign o_push_word.red          = i_red;
    assign o_push_word.chroma_valid = !r_row_count[0] && !r_column_count[0];
    assign o_push_word.line_end     = line_end;
    assign o_push_word.frame_end    = frame_end;

endmodule

`default_nettype wire

// File: hw/rtl/bty_queue.sv
// Short word queue between front and back ends.
// Depends on bty_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bty_queue
    import bty_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_pix_word i_push_word,
    input  wire logic      i_pop,
    output t_pix_word      o_head_word,
    output t_queue_status  o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pix_word     r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head_word    = r_mem[r_rd_ptr];

    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bty_back.sv
// Back end: two-stage color conversion, products then sums, into the output register.
// Depends on bty_pkg; drains bty_queue.
`timescale 1ns / 1ps
`default_nettype none

module bty_back
    import bty_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_pix_word     i_head_word,
    input  wire t_queue_status i_queue_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_luma,
    output logic               o_chroma_valid,
    output logic [7:0]         o_chroma_blue,
    output logic [7:0]         o_chroma_red,
    output logic               o_line_end,
    output logic               o_frame_end
);

    logic        advance;
    logic        r_s1_valid;
    logic [15:0] r_y_r, r_y_g, r_y_b;
    logic [15:0] r_cb_r, r_cb_g, r_cb_b;
    logic [15:0] r_cr_r, r_cr_g, r_cr_b;
    logic        r_s1_cv, r_s1_le, r_s1_fe;
    logic [15:0] y_sum, cb_sum, cr_sum;

    // hold the whole pipe while a finished word waits
    assign advance = !o_out_valid || i_out_ready;
    assign o_pop   = advance && !i_queue_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= !i_queue_status.empty;
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_y_r   <= 16'(i_head_word.red)   * C_Y_R;
            r_y_g   <= 16'(i_head_word.green) * C_Y_G;
            r_y_b   <= 16'(i_head_word.blue)  * C_Y_B;
            r_cb_r  <= 16'(i_head_word.red)   * C_CB_R;
            r_cb_g  <= 16'(i_head_word.green) * C_CB_G;
            r_cb_b  <= 16'(i_head_word.blue)  * C_CB_B;
            r_cr_r  <= 16'(i_head_word.red)   * C_CR_R;
            r_cr_g  <= 16'(i_head_word.green) * C_CR_G;
            r_cr_b  <= 16'(i_head_word.blue)  * C_CR_B;
            r_s1_cv <= i_head_word.chroma_valid;
            r_s1_le <= i_head_word.line_end;
            r_s1_fe <= i_head_word.frame_end;
        end
    end

    assign y_sum  = r_y_r + r_y_g + r_y_b;
    assign cb_sum = CHROMA_BIAS + r_cb_b - r_cb_r - r_cb_g;
    assign cr_sum = CHROMA_BIAS + r_cr_r - r_cr_g - r_cr_b;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_luma         <= y_sum[15:8] + Y_OFFSET;
            o_chroma_valid <= r_s1_cv;
            o_chroma_blue  <= r_s1_cv ? cb_sum[15:8] : 8'd0;
            o_chroma_red   <= r_s1_cv ? cr_sum[15:8] : 8'd0;
            o_line_end     <= r_s1_le;
            o_frame_end    <= r_s1_fe;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bgra_to_yuv420_converter.sv
// Top level of the BGRA to YUV 4:2:0 converter: APB registers, front, queue, back.
// Depends on bty_pkg, bty_front, bty_queue and bty_back.
//
// Takes one pixel word per clock while the queue is not full and returns one result word
// per pixel, in order, via the queue, the product registers and the output register. The
// sustained rate of one word per clock is set by the fully pipelined back end (one product
// stage, one sum stage); a four-word queue lets the input side keep accepting while the
// output stalls. Luma comes from every pixel; Cb and Cr are sampled at even row and even
// column and are zero otherwise. frame_width (offset 0) and frame_height (offset 4) must
// be written only while idle (unchecked); 0 acts as 1 and values above MAX_DIMENSION clamp.
`timescale 1ns / 1ps
`default_nettype none

module bgra_to_yuv420_converter
    import bty_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIM
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_blue,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_red,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [7:0]                 o_luma,
    output logic                       o_chroma_valid,
    output logic [7:0]                 o_chroma_blue,
    output logic [7:0]                 o_chroma_red,
    output logic                       o_line_end,
    output logic                       o_frame_end
);

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic             cfg_write;
    logic             push, pop;
    t_pix_word        push_word, head_word;
    t_queue_status    queue_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DEF_WIDTH;
            r_frame_height <= DEF_HEIGHT;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
        endcase
    end

    bty_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_push_word    (push_word)
    );

    bty_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_head_word (head_word),
        .o_status    (queue_status)
    );

    bty_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_word    (head_word),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_blue  (o_chroma_blue),
        .o_chroma_red   (o_chroma_red),
        .o_line_end     (o_line_end),
        .o_frame_end    (o_frame_end)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bty_checker.sv
// Port-level checks for the BGRA to YUV 4:2:0 converter, bound to the top level.
// Depends on bty_pkg and bgra_to_yuv420_converter.
`timescale 1ns / 1ps
`default_nettype none

module bty_checker
    import bty_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  pready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [7:0]            o_luma,
    input wire logic                  o_chroma_valid,
    input wire logic [7:0]            o_chroma_blue,
    input wire logic [7:0]            o_chroma_red,
    input wire logic                  o_line_end,
    input wire logic                  o_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_luma) && $stable(o_line_end))
        else $error("output word dropped or changed while stalled");

    a_frame_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_line_end)
        else $error("frame end without line end");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chroma_valid |-> o_chroma_blue == 8'd0 && o_chroma_red == 8'd0)
        else $error("chroma not cleared on a luma-only word");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_luma >= 8'd16 && o_luma <= 8'd235)
        else $error("luma out of studio range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind bgra_to_yuv420_converter bty_checker u_bty_checker (.*);

`default_nettype wire

// File: verif/bgra_to_yuv420_converter_tb.sv
// Testbench for bgra_to_yuv420_converter: directed and random pixel streams checked
// word by word against a built-in BT.601 luma/chroma and line/frame position predictor.
// Depends on bty_pkg and the converter RTL.
`timescale 1ns / 1ps

module bgra_to_yuv420_converter_tb;
    import bty_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 5;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       line_end;
        logic       frame_end;
    } t_yuv_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_blue;
    logic [7:0]            i_green;
    logic [7:0]            i_red;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_luma;
    logic                  o_chroma_valid;
    logic [7:0]            o_chroma_blue;
    logic [7:0]            o_chroma_red;
    logic                  o_line_end;
    logic                  o_frame_end;

    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    int               col_pos;
    int               row_pos;
    t_yuv_word        yuv_due[$];
    int               error_count = 0;
    int               quiet_cycles = 0;
    bit               hold_req;
    bit               send_gaps;
    bit               recv_gaps;

    bgra_to_yuv420_converter #(
        .MAX_DIMENSION(DEF_MAX_DIM)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_blue(i_blue),
        .i_green(i_green),
        .i_red(i_red),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_luma(o_luma),
        .o_chroma_valid(o_chroma_valid),
        .o_chroma_blue(o_chroma_blue),
        .o_chroma_red(o_chroma_red),
        .o_line_end(o_line_end),
        .o_frame_end(o_frame_end)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_MAX_DIM)
            return DEF_MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_yuv_word predict_yuv(input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r);
        t_yuv_word res;
        int        bb;
        int        gg;
        int        rr;
        int        last_col;
        int        last_row;
        bb = b;
        gg = g;
        rr = r;
        last_col = eff_dim(cfg_width) - 1;
        last_row = eff_dim(cfg_height) - 1;
        res.luma = 8'(((66 * rr + 129 * gg + 25 * bb) >> 8) + 16);
        res.chroma_valid = (row_pos % 2 == 0) && (col_pos % 2 == 0);
        res.chroma_blue = 8'd0;
        res.chroma_red = 8'd0;
        if (res.chroma_valid) begin
            res.chroma_blue = 8'((-38 * rr - 74 * gg + 112 * bb + 32768) >> 8);
            res.chroma_red = 8'((112 * rr - 94 * gg - 18 * bb + 32768) >> 8);
        end
        res.line_end = col_pos >= last_col;
        res.frame_end = 1'b0;
        if (res.line_end) begin
            col_pos = 0;
            res.frame_end = row_pos >= last_row;
            if (res.frame_end)
                row_pos = 0;
            else
                row_pos++;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_dim(input int lo, input int hi);
        logic [31:0] value;
        value = $urandom;
        case ($urandom_range(0, 9))
            0: value[CFG_W-1:0] = CFG_W'($urandom_range(0, 1));
            1: value[CFG_W-1:0] = CFG_W'($urandom_range(0, 8191));
            2: value[CFG_W-1:0] = CFG_W'(DEF_MAX_DIM);
            default: value[CFG_W-1:0] = CFG_W'($urandom_range(lo, hi));
        endcase
        return value;
    endfunction

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue <= b;
        i_green <= g;
        i_red <= r;
        do @(posedge i_clk); while (!o_in_ready);
        yuv_due.push_back(predict_yuv(b, g, r));
    endtask

    task automatic send_random_pixel();
        logic [7:0] c[3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0: c[k] = 8'h00;
                1: c[k] = 8'hFF;
                default: c[k] = 8'($urandom_range(0, 255));
            endcase
        end
        send_pixel(c[0], c[1], c[2]);
    endtask

    // drop valid and wait for the pipeline to empty before touching registers
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (yuv_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [31:0] width_val, input logic [31:0] height_val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_WIDTH;
        pwdata <= width_val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_width = width_val[CFG_W-1:0];
        penable <= 1'b0;
        paddr <= ADDR_HEIGHT;
        pwdata <= height_val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_height = height_val[CFG_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_default_geometry();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
    endtask

    task automatic test_tiny_frames();
        settle_idle();
        set_geometry(32'd2, 32'd1);
        repeat (3) send_random_pixel();
        settle_idle();
        set_geometry(32'd3, 32'd2);
        repeat (6) send_random_pixel();
    endtask

    task automatic test_clamped_sizes();
        settle_idle();
        set_geometry(32'd0, 32'd0);
        repeat (2) send_random_pixel();
        settle_idle();
        set_geometry(32'hFFFF_FFFF, 32'd4096);
        repeat (2) send_random_pixel();
    endtask

    task automatic test_resize_mid_frame();
        settle_idle();
        set_geometry(32'd8, 32'd4);
        repeat (5) send_random_pixel();
        settle_idle();
        set_geometry(32'd4, 32'd4);
        send_random_pixel();
        settle_idle();
        set_geometry(32'd4, 32'd1);
        send_random_pixel();
    endtask

    task automatic test_output_backpressure();
        settle_idle();
        set_geometry(32'd6, 32'd4);
        send_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_random_pixel();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        int sent;
        int n;
        sent = 0;
        while (sent < 560) begin
            settle_idle();
            set_geometry(pick_dim(2, 12), pick_dim(1, 6));
            n = $urandom_range(15, 60);
            repeat (n) send_random_pixel();
            sent += n;
        end
        // closing stretch runs at full rate on both sides
        settle_idle();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        set_geometry(32'($urandom_range(2, 12)), 32'($urandom_range(1, 6)));
        repeat (100) send_random_pixel();
    endtask

    initial begin : receiver
        int n;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) begin
                    @(posedge i_clk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_yuv_word seen;
        t_yuv_word due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_luma, o_chroma_valid, o_chroma_blue, o_chroma_red, o_line_end,
                    o_frame_end};
            if (yuv_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected word: luma %0d cv %0b cb %0d cr %0d le %0b fe %0b",
                             seen.luma, seen.chroma_valid, seen.chroma_blue, seen.chroma_red,
                             seen.line_end, seen.frame_end);
            end else begin
                due = yuv_due.pop_front();
                if (seen !== due) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: exp luma %0d cv %0b cb %0d cr %0d le %0b fe %0b",
                                 due.luma, due.chroma_valid, due.chroma_blue, due.chroma_red,
                                 due.line_end, due.frame_end);
                        $display("          got luma %0d cv %0b cb %0d cr %0d le %0b fe %0b",
                                 seen.luma, seen.chroma_valid, seen.chroma_blue,
                                 seen.chroma_red, seen.line_end, seen.frame_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("bgra_to_yuv420_converter_tb failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_blue = 8'h00;
        i_green = 8'h00;
        i_red = 8'h00;
        cfg_width = DEF_WIDTH;
        cfg_height = DEF_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        hold_req = 1'b0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_geometry();
        test_tiny_frames();
        test_clamped_sizes();
        test_resize_mid_frame();
        test_output_backpressure();
        test_random_frames();

        settle_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && yuv_due.size() == 0)
            $display("bgra_to_yuv420_converter_tb passed");
        else
            $display("bgra_to_yuv420_converter_tb failed");
        $finish;
    end

endmodule
